// ===== src/nine_slice_quad_generator_top_assert.svh =====
// Assertion macros for the nine-slice quad generator RTL.
// They expect clk and arst_n in scope.
`ifndef NINE_SLICE_QUAD_GENERATOR_TOP_ASSERT_SVH
`define NINE_SLICE_QUAD_GENERATOR_TOP_ASSERT_SVH

`define NSQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define NSQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/nsq_pkg.sv =====
package nsq_pkg;

	localparam int COORD_W      = 16;
	localparam int BORDER_W     = 14;
	localparam int TEX_W        = 13;
	localparam int ID_W         = 16;
	localparam int COLOR_W      = 32;
	localparam int UV_W         = 17;
	localparam int MAX_TEX_SIZE = 4096;
	localparam int UV_FRAC_BITS = 16;

	// radix-4 divider: two quotient bits per cycle, holding at the last step until the job is taken
	localparam int DIV_STEPS = (UV_FRAC_BITS + 1) / 2;
	localparam int QUO_W     = 2 * DIV_STEPS;
	localparam int DIV_PAD   = QUO_W - UV_FRAC_BITS;
	localparam int TEX16_W   = TEX_W + 4;
	localparam int DVSR_W    = TEX16_W + DIV_PAD;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int UVC_W     = UV_FRAC_BITS + 1;

	localparam logic [UVC_W-1:0] UV_ONE  = UVC_W'(1) << UV_FRAC_BITS;
	localparam logic [UVC_W-1:0] UV_HALF = UVC_W'(1) << (UV_FRAC_BITS - 1);

	localparam int NUM_CELLS  = 9;
	localparam int CELL_IDX_W = $clog2(NUM_CELLS);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [UV_W-1:0]           uv_t;
	typedef logic [BORDER_W-1:0]       border_t;
	typedef logic [TEX_W-1:0]          tex_t;
	typedef logic [ID_W-1:0]           id_t;
	typedef logic [COLOR_W-1:0]        color_t;
	typedef logic [NUM_CELLS-1:0]      cell_mask_t;
	typedef logic [CELL_IDX_W-1:0]     cell_idx_t;
	typedef coord_t [3:0]              coord4_t;
	typedef uv_t [3:0]                 uv4_t;

	typedef struct packed {
		logic [DVSR_W-1:0] rem;
		logic [QUO_W-1:0]  quo;
	} div_state_t;

	typedef struct packed {
		coord4_t    xs;
		coord4_t    ys;
		uv4_t       us;
		uv4_t       vs;
		id_t        tex;
		color_t     color;
		cell_mask_t mask;
	} nsq_job_t;

	function automatic logic [1:0] cell_row(cell_idx_t idx);
		logic [1:0] r;
		case (idx)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] cell_col(cell_idx_t idx);
		logic [1:0] c;
		case (idx)
			4'd0, 4'd3, 4'd6: c = 2'd0;
			4'd1, 4'd4, 4'd7: c = 2'd1;
			default: c = 2'd2;
		endcase
		return c;
	endfunction

endpackage

// ===== src/nsq_item_if.sv =====
interface nsq_item_if;
	import nsq_pkg::*;

	logic    valid;
	logic    ready;
	coord_t  rect_left;
	coord_t  rect_top;
	coord_t  rect_right;
	coord_t  rect_bottom;
	border_t border_size;
	tex_t    tex_width;
	tex_t    tex_height;
	id_t     texture_id;
	color_t  packed_color;

	modport source (
		output valid, rect_left, rect_top, rect_right, rect_bottom, border_size,
		       tex_width, tex_height, texture_id, packed_color,
		input  ready
	);

	modport sink (
		input  valid, rect_left, rect_top, rect_right, rect_bottom, border_size,
		       tex_width, tex_height, texture_id, packed_color,
		output ready
	);
endinterface

// ===== src/nsq_quad_if.sv =====
interface nsq_quad_if;
	import nsq_pkg::*;

	logic   valid;
	logic   ready;
	coord_t cell_left;
	coord_t cell_top;
	coord_t cell_right;
	coord_t cell_bottom;
	uv_t    u_start;
	uv_t    v_start;
	uv_t    u_end;
	uv_t    v_end;
	id_t    out_texture;
	color_t out_color;
	logic   last_cell;

	modport source (
		output valid, cell_left, cell_top, cell_right, cell_bottom, u_start, v_start,
		       u_end, v_end, out_texture, out_color, last_cell,
		input  ready
	);

	modport sink (
		input  valid, cell_left, cell_top, cell_right, cell_bottom, u_start, v_start,
		       u_end, v_end, out_texture, out_color, last_cell,
		output ready
	);
endinterface

// ===== src/nsq_front.sv =====
module nsq_front (
	input  logic              clk,
	input  logic              arst_n,
	nsq_item_if.sink          item,
	output logic              job_valid,
	input  logic              job_ready,
	output nsq_pkg::nsq_job_t job
);
	import nsq_pkg::*;
	`include "nine_slice_quad_generator_top_assert.svh"

	function automatic coord4_t cut_axis(coord_t lo, coord_t hi, border_t b);
		logic signed [COORD_W:0] ext;
		logic [COORD_W:0]        b2;
		coord4_t                 e;
		ext  = (COORD_W+1)'(hi) - (COORD_W+1)'(lo);
		b2   = (COORD_W+1)'({b, 1'b0});
		e[0] = lo;
		e[3] = hi;
		if (b2 > $unsigned(ext)) begin
			e[1] = COORD_W'((COORD_W+1)'(lo) + (ext >>> 1));
			e[2] = e[1];
		end else begin
			e[1] = COORD_W'((COORD_W+1)'(lo) + $signed((COORD_W+1)'(b)));
			e[2] = COORD_W'((COORD_W+1)'(hi) - $signed((COORD_W+1)'(b)));
		end
		return e;
	endfunction

	function automatic div_state_t div_step2(logic [DVSR_W-1:0] rem, logic [QUO_W-1:0] quo,
			logic [DVSR_W-1:0] dvsr);
		logic [DVSR_W:0] sh;
		div_state_t      s;
		s.rem = rem;
		s.quo = quo;
		for (int k = 0; k < 2; k++) begin
			sh = {s.rem, 1'b0};
			if (sh >= {1'b0, dvsr}) begin
				s.rem = DVSR_W'(sh - {1'b0, dvsr});
				s.quo = {s.quo[QUO_W-2:0], 1'b1};
			end else begin
				s.rem = DVSR_W'(sh);
				s.quo = {s.quo[QUO_W-2:0], 1'b0};
			end
		end
		return s;
	endfunction

	function automatic uv4_t uv_axis(logic clamp, logic [QUO_W-1:0] q);
		logic [UVC_W-1:0] qq;
		uv4_t             t;
		qq   = UVC_W'(q);
		t[0] = '0;
		t[3] = UV_W'(UV_ONE);
		t[1] = clamp ? UV_W'(UV_HALF) : UV_W'(qq);
		t[2] = clamp ? UV_W'(UV_HALF) : UV_W'(UV_ONE - qq);
		return t;
	endfunction

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	coord4_t           ex_q;
	coord4_t           ey_q;
	logic              clamp_u_q;
	logic              clamp_v_q;
	logic [DVSR_W-1:0] du_q;
	logic [DVSR_W-1:0] dv_q;
	logic [DVSR_W-1:0] ru_q;
	logic [DVSR_W-1:0] rv_q;
	logic [QUO_W-1:0]  qu_q;
	logic [QUO_W-1:0]  qv_q;
	id_t               tex_q;
	color_t            color_q;

	logic signed [COORD_W:0] ext_x;
	logic signed [COORD_W:0] ext_y;
	logic                    item_ok;
	logic                    final_step;
	logic                    advance;
	logic                    accept;
	div_state_t              nu;
	div_state_t              nv;
	logic [2:0]              cx;
	logic [2:0]              ry;

	always_comb begin
		ext_x   = (COORD_W+1)'(item.rect_right) - (COORD_W+1)'(item.rect_left);
		ext_y   = (COORD_W+1)'(item.rect_bottom) - (COORD_W+1)'(item.rect_top);
		item_ok = (ext_x > 0) && (ext_y > 0) && (item.border_size != '0)
			&& (item.tex_width != '0) && (item.tex_height != '0)
			&& (32'(item.tex_width) <= MAX_TEX_SIZE)
			&& (32'(item.tex_height) <= MAX_TEX_SIZE);
	end

	assign final_step = busy_q && (step_q == STEP_W'(DIV_STEPS - 1));
	assign advance    = busy_q && (!final_step || job_ready);
	assign item.ready = !busy_q || (final_step && job_ready);
	assign accept     = item.valid && item.ready;
	assign job_valid  = final_step;

	always_comb begin
		nu = div_step2(ru_q, qu_q, du_q);
		nv = div_step2(rv_q, qv_q, dv_q);
		for (int c = 0; c < 3; c++) begin
			cx[c] = ex_q[c+1] > ex_q[c];
			ry[c] = ey_q[c+1] > ey_q[c];
		end
		job.xs    = ex_q;
		job.ys    = ey_q;
		job.us    = uv_axis(clamp_u_q, nu.quo);
		job.vs    = uv_axis(clamp_v_q, nv.quo);
		job.tex   = tex_q;
		job.color = color_q;
		for (int i = 0; i < NUM_CELLS; i++) begin
			job.mask[i] = cx[i % 3] & ry[i / 3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= item_ok;
			step_q <= '0;
		end else if (advance) begin
			busy_q <= !final_step;
			step_q <= final_step ? '0 : step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ex_q      <= cut_axis(item.rect_left, item.rect_right, item.border_size);
			ey_q      <= cut_axis(item.rect_top, item.rect_bottom, item.border_size);
			clamp_u_q <= TEX16_W'({item.border_size, 1'b0}) > {item.tex_width, 4'b0};
			clamp_v_q <= TEX16_W'({item.border_size, 1'b0}) > {item.tex_height, 4'b0};
			du_q      <= {item.tex_width, {(4 + DIV_PAD){1'b0}}};
			dv_q      <= {item.tex_height, {(4 + DIV_PAD){1'b0}}};
			ru_q      <= DVSR_W'(item.border_size);
			rv_q      <= DVSR_W'(item.border_size);
			qu_q      <= '0;
			qv_q      <= '0;
			tex_q     <= item.texture_id;
			color_q   <= item.packed_color;
		end else if (advance) begin
			ru_q <= nu.rem;
			rv_q <= nv.rem;
			qu_q <= nu.quo;
			qv_q <= nv.quo;
		end
	end

	`NSQ_ASSERT_IMPLY(a_u_quo_bound, final_step && !clamp_u_q, UVC_W'(nu.quo) <= UV_HALF, "u quotient above one half")
	`NSQ_ASSERT_IMPLY(a_v_quo_bound, final_step && !clamp_v_q, UVC_W'(nv.quo) <= UV_HALF, "v quotient above one half")
endmodule

// ===== src/nsq_fifo.sv =====
module nsq_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  nsq_pkg::nsq_job_t push_job,
	output logic              pop_valid,
	input  logic              pop_ready,
	output nsq_pkg::nsq_job_t pop_job
);
	import nsq_pkg::*;
	`include "nine_slice_quad_generator_top_assert.svh"

	nsq_job_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = cnt_q != QCNT_W'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	`NSQ_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= QCNT_W'(QDEPTH), "queue count above depth")
endmodule

// ===== src/nsq_back.sv =====
module nsq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  nsq_pkg::nsq_job_t job,
	nsq_quad_if.source        quad
);
	import nsq_pkg::*;
	`include "nine_slice_quad_generator_top_assert.svh"

	logic       active_q;
	cell_mask_t rem_q;
	nsq_job_t   job_q;
	logic       ovld_q;
	coord_t     left_q;
	coord_t     top_q;
	coord_t     right_q;
	coord_t     bottom_q;
	uv_t        us_q;
	uv_t        vs_q;
	uv_t        ue_q;
	uv_t        ve_q;
	id_t        otex_q;
	color_t     ocolor_q;
	logic       last_q;

	logic       advance;
	logic       emit;
	logic       pop;
	cell_mask_t low;
	cell_mask_t rest;
	cell_idx_t  idx;
	logic [1:0] row;
	logic [1:0] col;
	logic [1:0] row1;
	logic [1:0] col1;

	always_comb begin
		advance = !ovld_q || quad.ready;
		emit    = active_q && advance;
		low     = rem_q & (~rem_q + NUM_CELLS'(1));
		rest    = rem_q & (rem_q - NUM_CELLS'(1));
		idx     = '0;
		for (int i = 0; i < NUM_CELLS; i++) begin
			if (low[i]) begin
				idx = idx | CELL_IDX_W'(i);
			end
		end
		row       = cell_row(idx);
		col       = cell_col(idx);
		row1      = row + 2'd1;
		col1      = col + 2'd1;
		job_ready = !active_q || (emit && (rest == '0));
		pop       = job_valid && job_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rem_q    <= '0;
			ovld_q   <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= job.mask != '0;
				rem_q    <= job.mask;
			end else if (emit) begin
				active_q <= rest != '0;
				rem_q    <= rest;
			end
			if (emit) begin
				ovld_q <= 1'b1;
			end else if (quad.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (emit) begin
			left_q   <= job_q.xs[col];
			right_q  <= job_q.xs[col1];
			top_q    <= job_q.ys[row];
			bottom_q <= job_q.ys[row1];
			us_q     <= job_q.us[col];
			ue_q     <= job_q.us[col1];
			vs_q     <= job_q.vs[row];
			ve_q     <= job_q.vs[row1];
			otex_q   <= job_q.tex;
			ocolor_q <= job_q.color;
			last_q   <= rest == '0;
		end
	end

	assign quad.valid       = ovld_q;
	assign quad.cell_left   = left_q;
	assign quad.cell_top    = top_q;
	assign quad.cell_right  = right_q;
	assign quad.cell_bottom = bottom_q;
	assign quad.u_start     = us_q;
	assign quad.v_start     = vs_q;
	assign quad.u_end       = ue_q;
	assign quad.v_end       = ve_q;
	assign quad.out_texture = otex_q;
	assign quad.out_color   = ocolor_q;
	assign quad.last_cell   = last_q;

	`NSQ_ASSERT_IMPLY(a_active_has_cells, active_q, rem_q != '0, "active job with no cells left")
endmodule

// ===== src/nine_slice_quad_generator_top.sv =====
// Nine-slice quad generator: one rectangle transfer in, up to nine textured quads out.
// An accepted item is registered in the front end, runs the radix-4 UV divider, passes the
// job FIFO and the back end's job register, and leaves through the quad output register.
// The rate is set by the radix-4 UV divider and the one-quad-per-cycle output register, held by
// quad.ready; the front end takes a new item as it hands off its job and drops a rejected item.
// Reset: arst_n clears all control state asynchronously; the block is ready right after reset.
module nine_slice_quad_generator_top (
	input  logic       clk,
	input  logic       arst_n,
	nsq_item_if.sink   item,
	nsq_quad_if.source quad
);
	import nsq_pkg::*;

	logic     f_valid;
	logic     f_ready;
	nsq_job_t f_job;
	logic     b_valid;
	logic     b_ready;
	nsq_job_t b_job;

	nsq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	nsq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_job   (f_job),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_job    (b_job)
	);

	nsq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job       (b_job),
		.quad      (quad)
	);
endmodule
